/* hw/rtl/stag_pkg.sv */
// Shared types and constants of the strided tensor address generator.
package stag_pkg;

   localparam int MAX_RANK   = 3;
   localparam int IDX_W      = 48;
   localparam int SIZE_W     = 16;
   localparam int STRIDE_W   = 32;
   localparam int ESIZE_W    = 8;
   localparam int DEST_W     = 56;
   localparam int SRC_W      = 63;
   localparam int PROD_W     = SIZE_W + 1 + STRIDE_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int SCALED_W   = SUM_W + ESIZE_W + 1;
   localparam int DIVA_STEPS = IDX_W;
   localparam int DIVB_STEPS = IDX_W - SIZE_W;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_ELEMENT_SIZE  = 3'd0;
   localparam reg_idx_type REG_SIZE_OUTER    = 3'd1;
   localparam reg_idx_type REG_SIZE_MIDDLE   = 3'd2;
   localparam reg_idx_type REG_SIZE_INNER    = 3'd3;
   localparam reg_idx_type REG_STRIDE_OUTER  = 3'd4;
   localparam reg_idx_type REG_STRIDE_MIDDLE = 3'd5;
   localparam reg_idx_type REG_STRIDE_INNER  = 3'd6;

   // One beat in flight through the divider chains.
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [IDX_W-1:0]  word;
      logic [SIZE_W-1:0] rem;
      logic [SIZE_W-1:0] crd_inner;
   } pipe_type;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [ESIZE_W-1:0]         esize;
      logic [SIZE_W-1:0]          size_inner;
      logic [SIZE_W-1:0]          size_middle;
      logic signed [STRIDE_W-1:0] stride_outer;
      logic signed [STRIDE_W-1:0] stride_middle;
      logic signed [STRIDE_W-1:0] stride_inner;
      logic [IDX_W-1:0]           product;
   } cfg_type;

endpackage

/* hw/rtl/strided_tensor_address_generator_unit.sv */
// Top level of the strided tensor address generator.
//
// Usage: each req beat carries a row-major element index of a contiguous
// destination. The block splits it over inner, middle and outer extents,
// weights the coordinates by signed source strides and returns one rsp beat
// with destination and source byte offsets, an in-range flag and a
// last-element flag. Indexes at or past the extent product return in_range 0
// and a zero source offset.
// Extents, strides and element size sit in an APB register file; write them
// only while no beat is in flight.
// Pipeline from req accept to rsp valid: 48 quotient-bit stages divide by
// the inner extent, 32 more divide by the middle extent, then three stages
// multiply, sum and scale. Throughput: one beat per cycle while no beat is
// held under rsp_stall, set by the fully pipelined divider chain.
// Reset clears all valid bits and loads register defaults (extents 1,
// inner stride 1, element size 1).
// Stall: while rsp holds a beat under rsp_stall, every stage freezes,
// bubbles included, and req_stall is raised; nothing is lost or repeated.
module strided_tensor_address_generator_unit
   import stag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IDX_W-1:0]      req_element_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DEST_W-1:0]     rsp_dest_byte_offset,
   output logic [SRC_W-1:0]      rsp_source_byte_offset,
   output logic                  rsp_in_range,
   output logic                  rsp_last_element,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   logic     advance;
   pipe_type chain_a [0:DIVA_STEPS];
   pipe_type chain_b [0:DIVB_STEPS];

   // freeze only when the output beat is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   stag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // entry: dividend is the index, partial remainder zero
   always_comb begin
      chain_a[0].valid     = req_valid;
      chain_a[0].idx       = req_element_index;
      chain_a[0].word      = req_element_index;
      chain_a[0].rem       = '0;
      chain_a[0].crd_inner = '0;
   end

   for (genvar i = 0; i < DIVA_STEPS; i++) begin : g_div_inner
      stag_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .divisor  (cfg.size_inner),
         .beat_in  (chain_a[i]),
         .beat_out (chain_a[i+1])
      );
   end

   // remainder is the inner coordinate; quotient is left-aligned for the
   // middle divide (quotient fits below 2^32 whenever the index is in range)
   always_comb begin
      chain_b[0].valid     = chain_a[DIVA_STEPS].valid;
      chain_b[0].idx       = chain_a[DIVA_STEPS].idx;
      chain_b[0].word      = {chain_a[DIVA_STEPS].word[DIVB_STEPS-1:0], SIZE_W'(0)};
      chain_b[0].rem       = '0;
      chain_b[0].crd_inner = chain_a[DIVA_STEPS].rem;
   end

   for (genvar j = 0; j < DIVB_STEPS; j++) begin : g_div_middle
      stag_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .divisor  (cfg.size_middle),
         .beat_in  (chain_b[j]),
         .beat_out (chain_b[j+1])
      );
   end

   stag_math u_math (
      .clock                  (clock),
      .reset                  (reset),
      .advance                (advance),
      .beat_in                (chain_b[DIVB_STEPS]),
      .cfg                    (cfg),
      .rsp_valid              (rsp_valid),
      .rsp_dest_byte_offset   (rsp_dest_byte_offset),
      .rsp_source_byte_offset (rsp_source_byte_offset),
      .rsp_in_range           (rsp_in_range),
      .rsp_last_element       (rsp_last_element)
   );

endmodule

/* hw/rtl/stag_div_step.sv */
// One registered step of a restoring divider: one quotient bit per stage.
module stag_div_step
   import stag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [SIZE_W-1:0] divisor,
   input  pipe_type          beat_in,
   output pipe_type          beat_out
);

   logic              valid_ff;
   pipe_type          data_ff;
   pipe_type          data_in;
   logic [SIZE_W:0]   shifted;
   logic              qbit;

   always_comb begin
      shifted = {beat_in.rem, beat_in.word[IDX_W-1]};
      qbit    = (shifted >= {1'b0, divisor});
      data_in = beat_in;
      if (qbit) begin
         data_in.rem = SIZE_W'(shifted - {1'b0, divisor});
      end else begin
         data_in.rem = shifted[SIZE_W-1:0];
      end
      data_in.word = {beat_in.word[IDX_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      beat_out       = data_ff;
      beat_out.valid = valid_ff;
   end

endmodule

/* hw/rtl/stag_csr.sv */
// APB register file and precomputed size product.
module stag_csr
   import stag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [ESIZE_W-1:0]         esize_ff;
   logic [SIZE_W-1:0]          size_outer_ff;
   logic [SIZE_W-1:0]          size_middle_ff;
   logic [SIZE_W-1:0]          size_inner_ff;
   logic signed [STRIDE_W-1:0] stride_outer_ff;
   logic signed [STRIDE_W-1:0] stride_middle_ff;
   logic signed [STRIDE_W-1:0] stride_inner_ff;
   logic [2*SIZE_W-1:0]        prod_lo_ff;
   logic [IDX_W-1:0]           product_ff;
   logic [SIZE_W-1:0]          size_middle_eff;
   logic [SIZE_W-1:0]          size_outer_eff;
   logic                       wr_en;
   reg_idx_type                reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         esize_ff         <= ESIZE_W'(1);
         size_outer_ff    <= SIZE_W'(1);
         size_middle_ff   <= SIZE_W'(1);
         size_inner_ff    <= SIZE_W'(1);
         stride_outer_ff  <= '0;
         stride_middle_ff <= '0;
         stride_inner_ff  <= STRIDE_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ELEMENT_SIZE:  esize_ff         <= csr_pwdata[ESIZE_W-1:0];
            REG_SIZE_OUTER:    size_outer_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_MIDDLE:   size_middle_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_INNER:    size_inner_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_STRIDE_OUTER:  stride_outer_ff  <= csr_pwdata[STRIDE_W-1:0];
            REG_STRIDE_MIDDLE: stride_middle_ff <= csr_pwdata[STRIDE_W-1:0];
            REG_STRIDE_INNER:  stride_inner_ff  <= csr_pwdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ELEMENT_SIZE:  csr_prdata = CSR_DATA_W'(esize_ff);
         REG_SIZE_OUTER:    csr_prdata = CSR_DATA_W'(size_outer_ff);
         REG_SIZE_MIDDLE:   csr_prdata = CSR_DATA_W'(size_middle_ff);
         REG_SIZE_INNER:    csr_prdata = CSR_DATA_W'(size_inner_ff);
         REG_STRIDE_OUTER:  csr_prdata = stride_outer_ff;
         REG_STRIDE_MIDDLE: csr_prdata = stride_middle_ff;
         REG_STRIDE_INNER:  csr_prdata = stride_inner_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // dimensions beyond the rank count as extent 1, stride ignored
   assign size_middle_eff = (MAX_RANK >= 2) ? size_middle_ff : SIZE_W'(1);
   assign size_outer_eff  = (MAX_RANK >= 3) ? size_outer_ff  : SIZE_W'(1);

   // product settles via prod_lo_ff after a write, well before a beat uses it
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_lo_ff <= (2*SIZE_W)'(1);
         product_ff <= IDX_W'(1);
      end else begin
         prod_lo_ff <= (2*SIZE_W)'(size_inner_ff) * (2*SIZE_W)'(size_middle_eff);
         product_ff <= IDX_W'(prod_lo_ff) * IDX_W'(size_outer_eff);
      end
   end

   always_comb begin
      cfg.esize         = esize_ff;
      cfg.size_inner    = size_inner_ff;
      cfg.size_middle   = size_middle_eff;
      cfg.stride_inner  = stride_inner_ff;
      cfg.stride_middle = (MAX_RANK >= 2) ? stride_middle_ff : '0;
      cfg.stride_outer  = (MAX_RANK >= 3) ? stride_outer_ff  : '0;
      cfg.product       = product_ff;
   end

endmodule

/* hw/rtl/stag_math.sv */
// Stride weighting, range check and byte scaling: three register stages.
module stag_math
   import stag_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  pipe_type           beat_in,
   input  cfg_type            cfg,
   output logic               rsp_valid,
   output logic [DEST_W-1:0]  rsp_dest_byte_offset,
   output logic [SRC_W-1:0]   rsp_source_byte_offset,
   output logic               rsp_in_range,
   output logic               rsp_last_element
);

   logic [SIZE_W-1:0]        crd_middle;
   logic [SIZE_W-1:0]        crd_outer;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [PROD_W-1:0] p_inner_ff, p_middle_ff, p_outer_ff;
   logic [DEST_W-1:0]        dest1_ff, dest2_ff, dest3_ff;
   logic                     inr1_ff, inr2_ff, inr3_ff;
   logic                     last1_ff, last2_ff, last3_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SCALED_W-1:0] scaled;
   logic [SRC_W-1:0]         src3_ff;

   assign crd_middle = beat_in.rem;
   assign crd_outer  = beat_in.word[SIZE_W-1:0];  // quotient below outer extent when in range

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= beat_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign scaled = sum_ff * $signed({1'b0, cfg.esize});

   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1: coordinate times stride, dest scaling, range compare
         p_inner_ff  <= PROD_W'($signed({1'b0, beat_in.crd_inner})) *
                        PROD_W'($signed(cfg.stride_inner));
         p_middle_ff <= PROD_W'($signed({1'b0, crd_middle})) *
                        PROD_W'($signed(cfg.stride_middle));
         p_outer_ff  <= PROD_W'($signed({1'b0, crd_outer})) *
                        PROD_W'($signed(cfg.stride_outer));
         dest1_ff    <= DEST_W'(beat_in.idx) * DEST_W'(cfg.esize);
         inr1_ff     <= beat_in.idx < cfg.product;
         last1_ff    <= (beat_in.idx < cfg.product) &&
                        (beat_in.idx == cfg.product - IDX_W'(1));
         // stage 2: element offset sum
         sum_ff      <= SUM_W'(p_inner_ff) + SUM_W'(p_middle_ff) + SUM_W'(p_outer_ff);
         dest2_ff    <= dest1_ff;
         inr2_ff     <= inr1_ff;
         last2_ff    <= last1_ff;
         // stage 3: byte scaling, zero when out of range
         src3_ff     <= inr2_ff ? SRC_W'(scaled) : '0;
         dest3_ff    <= dest2_ff;
         inr3_ff     <= inr2_ff;
         last3_ff    <= last2_ff;
      end
   end

   assign rsp_valid              = v3_ff;
   assign rsp_dest_byte_offset   = dest3_ff;
   assign rsp_source_byte_offset = src3_ff;
   assign rsp_in_range           = inr3_ff;
   assign rsp_last_element       = last3_ff;

endmodule

/* hw/rtl/stag_checker.sv */
// Port-level checks for the strided tensor address generator, bound to the top.
module stag_checker
   import stag_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DEST_W-1:0]     rsp_dest_byte_offset,
   input logic [SRC_W-1:0]      rsp_source_byte_offset,
   input logic                  rsp_in_range,
   input logic                  rsp_last_element
);

   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_element |-> rsp_in_range)
      else $error("last element flagged out of range");

   a_oor_zero_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_source_byte_offset == '0)
      else $error("out-of-range beat has nonzero source offset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_byte_offset))
      else $error("stalled rsp beat changed");

endmodule

bind strided_tensor_address_generator_unit stag_checker u_stag_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_dest_byte_offset   (rsp_dest_byte_offset),
   .rsp_source_byte_offset (rsp_source_byte_offset),
   .rsp_in_range           (rsp_in_range),
   .rsp_last_element       (rsp_last_element)
);
